@@ hw/rtl/matrix4_multiply_macros.svh @@
// assertion macros used by the checker of matrix4_multiply
// depends on nothing; each use wants a label, clock, reset (not the _ALWAYS form), antecedent, consequent and message
`ifndef MATRIX4_MULTIPLY_MACROS_SVH
`define MATRIX4_MULTIPLY_MACROS_SVH

// same-cycle implication, off during reset
`define M4M_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define M4M_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define M4M_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/m4m_pkg.sv @@
// types and constants of the 4x4 fixed-point matrix multiplier
// used by the controller, the datapath, the top level and the checker
`timescale 1ns / 1ps

package m4m_pkg;

  // matrix geometry
  localparam int DIM    = 4;
  localparam int CELLS  = DIM * DIM;
  localparam int IDX_W  = $clog2(CELLS);
  localparam int K_W    = $clog2(DIM);
  localparam int STEP_W = IDX_W + K_W;

  // data widths
  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + K_W;

  localparam logic [K_W-1:0]    K_LAST     = K_W'(DIM - 1);
  localparam logic [IDX_W-1:0]  LAST_INDEX = IDX_W'(CELLS - 1);
  localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(CELLS * DIM - 1);

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

  // operation codes
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE    = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic              issue;
    logic [STEP_W-1:0] step;
    logic              wr_left;
    logic              wr_right;
  } m4m_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hold;
  } m4m_status_t;

endpackage

@@ hw/rtl/m4m_ctrl.sv @@
// controller of the matrix multiplier: input transfers and the product sequencer
// depends on m4m_pkg; drives m4m_datapath through m4m_cmd_t
`timescale 1ns / 1ps

module m4m_ctrl import m4m_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   operation,
  input  m4m_status_t       status,
  output m4m_cmd_t          cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t              state, state_next;
  logic [STEP_W-1:0]   step, step_next;
  logic                accept;

  // inputs are taken only between products
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // next state and step counter
  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      ST_IDLE: begin
        if (accept && operation == OP_COMPUTE) begin
          state_next = ST_RUN;
          step_next  = '0;
        end
      end
      ST_RUN: begin
        if (!status.hold) begin
          step_next = step + STEP_W'(1);
          if (step == STEP_LAST) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // commands to the datapath
  always_comb begin
    cmd.issue    = (state == ST_RUN);
    cmd.step     = step;
    cmd.wr_left  = accept && operation == OP_LOAD_LEFT;
    cmd.wr_right = accept && operation == OP_LOAD_RIGHT;
  end

endmodule

@@ hw/rtl/m4m_datapath.sv @@
// datapath of the matrix multiplier: both stores, one shared multiply-accumulate
// pipeline, saturation and the output register; depends on m4m_pkg
`timescale 1ns / 1ps

module m4m_datapath import m4m_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  m4m_cmd_t                 cmd,
  output m4m_status_t              status,
  input  logic [IDX_W-1:0]         wr_index,
  input  logic signed [DATA_W-1:0] wr_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         result_index,
  output logic signed [DATA_W-1:0] result_value,
  output logic                     saturated,
  output logic                     last
);

  logic [DATA_W-1:0] left_store  [CELLS];
  logic [DATA_W-1:0] right_store [CELLS];

  logic                     advance;
  logic [K_W-1:0]           step_k;
  logic [K_W-1:0]           step_row;
  logic [K_W-1:0]           step_col;
  logic [IDX_W-1:0]         addr_left;
  logic [IDX_W-1:0]         addr_right;

  logic                     s1_valid;
  logic                     s1_first;
  logic                     s1_last;
  logic [IDX_W-1:0]         s1_index;
  logic signed [DATA_W-1:0] a_q;
  logic signed [DATA_W-1:0] b_q;

  logic                     s2_valid;
  logic                     s2_first;
  logic                     s2_last;
  logic [IDX_W-1:0]         s2_index;
  logic signed [PROD_W-1:0] prod_q;

  logic signed [PROD_W-1:0] shifted;
  logic signed [ACC_W-1:0]  term;
  logic                     s3_valid;
  logic [IDX_W-1:0]         s3_index;
  logic signed [ACC_W-1:0]  acc;

  logic                     in_range;
  logic [DATA_W-1:0]        clamp_value;

  // whole pipeline freezes while a result waits on a stalled output
  assign advance     = !(out_valid && out_stall);
  assign status.hold = !advance;

  // step is {column, row, k}
  assign step_k     = cmd.step[K_W-1:0];
  assign step_row   = cmd.step[K_W +: K_W];
  assign step_col   = cmd.step[2*K_W +: K_W];
  assign addr_left  = {step_k, step_row};
  assign addr_right = {step_col, step_k};

  // element stores, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        left_store[i]  <= '0;
        right_store[i] <= '0;
      end
    end else begin
      if (cmd.wr_left) begin
        left_store[wr_index] <= wr_value;
      end
      if (cmd.wr_right) begin
        right_store[wr_index] <= wr_value;
      end
    end
  end

  // stage 1: registered operand read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_q      <= left_store[addr_left];
      b_q      <= right_store[addr_right];
      s1_first <= (step_k == '0);
      s1_last  <= (step_k == K_LAST);
      s1_index <= cmd.step[STEP_W-1:K_W];
    end
  end

  // stage 2: signed product
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_q   <= a_q * b_q;
      s2_first <= s1_first;
      s2_last  <= s1_last;
      s2_index <= s1_index;
    end
  end

  // stage 3: truncating shift and exact accumulation
  assign shifted = prod_q >>> FRAC_BITS;
  assign term    = {{K_W{shifted[PROD_W-1]}}, shifted};

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid && s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_index <= s2_index;
      if (s2_valid) begin
        acc <= s2_first ? term : acc + term;
      end
    end
  end

  // saturation to the 32-bit range
  assign in_range    = (&acc[ACC_W-1:DATA_W-1]) || !(|acc[ACC_W-1:DATA_W-1]);
  assign clamp_value = acc[ACC_W-1] ? SAT_MIN : SAT_MAX;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s3_valid) begin
      result_index <= s3_index;
      result_value <= in_range ? acc[DATA_W-1:0] : clamp_value;
      saturated    <= !in_range;
      last         <= (s3_index == LAST_INDEX);
    end
  end

endmodule

@@ hw/rtl/matrix4_multiply.sv @@
// top level of the 4x4 signed Q16.16 matrix multiplier
// depends on m4m_pkg, m4m_ctrl and m4m_datapath
//
//   channel  handshake            payload
//   input    in_valid / in_stall  operation, element_index, element_value
//   output   out_valid / out_stall result_index, result_value, saturated, last
//
// a load transfer writes one element; a compute issues 64 multiply steps, one a cycle
// unless the output is stalled, through the single shared multiplier, so a result
// leaves after every four multiply steps
// input is stalled while a compute is being issued
// a stalled output freezes the multiply pipeline and the issue counter
// synchronous reset clears both stores, the pipeline and the output
`timescale 1ns / 1ps

module matrix4_multiply import m4m_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          operation,
  input  logic [IDX_W-1:0]         element_index,
  input  logic signed [DATA_W-1:0] element_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         result_index,
  output logic signed [DATA_W-1:0] result_value,
  output logic                     saturated,
  output logic                     last
);

  m4m_cmd_t    cmd;
  m4m_status_t status;

  // sequencer
  m4m_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .status    (status),
    .cmd       (cmd)
  );

  // stores and arithmetic
  m4m_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .wr_index     (element_index),
    .wr_value     (element_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_index (result_index),
    .result_value (result_value),
    .saturated    (saturated),
    .last         (last)
  );

endmodule

@@ hw/rtl/m4m_checker.sv @@
// port-level checks of matrix4_multiply, attached by the bind at the end
// depends on m4m_pkg and matrix4_multiply_macros.svh
`timescale 1ns / 1ps
`include "matrix4_multiply_macros.svh"

module m4m_checker import m4m_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [OP_W-1:0]          operation,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [IDX_W-1:0]         result_index,
  input logic signed [DATA_W-1:0] result_value,
  input logic                     saturated,
  input logic                     last
);

  // reset leaves nothing to deliver and the input open
  `M4M_ASSERT_NEXT_ALWAYS(a_reset_clear, clk, rst, !out_valid && !in_stall, "state after reset")

  // a compute transfer closes the input
  `M4M_ASSERT_NEXT(a_compute_stalls, clk, rst, in_valid && !in_stall && operation == OP_COMPUTE, in_stall, "input open after compute")

  // a load transfer leaves the input open
  `M4M_ASSERT_NEXT(a_load_open, clk, rst, in_valid && !in_stall && operation != OP_COMPUTE, !in_stall, "input closed after load")

  // the final element sits at the last position
  `M4M_ASSERT_IMPL(a_last_index, clk, rst, out_valid && last, result_index == LAST_INDEX, "last on wrong element")

  // a stalled result holds
  `M4M_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(result_index) && $stable(result_value) && $stable(saturated) && $stable(last), "stalled result changed")

endmodule

bind matrix4_multiply m4m_checker u_checker (.*);
